@@ design/tss_pkg.sv @@
// Shared constants for the 2-SAT component solver.
package tss_pkg;

  // Result status codes
  localparam logic [1:0] STATUS_SAT = 2'd0;
  localparam logic [1:0] STATUS_UNSAT = 2'd1;
  localparam logic [1:0] STATUS_DROPPED = 2'd2;

endpackage

@@ design/tss_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module tss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/two_sat_scc_solver.sv @@
// Top level of the 2-SAT solver: clause loading, Tarjan search and answer output.
//
// Clauses are loaded one at a time. While a request waits with in_stall high, the head
// of the first endpoint's list is fetched; then the request is accepted, the first
// implication edge is written and the other endpoint's head fetched; then the other edge is
// written. A dropped clause is accepted and writes no edge. After the clause marked
// last, the block accepts nothing until the answer has been delivered. Before the first
// clause after reset, and after every answer, a clearing pass sweeps all 2*VAR_LIMIT+1
// addresses (2049 by default) of the head, visit and on-stack memories; configuration
// writes are taken then, or in the idle load state, while no clause is waiting. Solving
// runs on memories with a registered read port: the root scan reads each node's visit
// order and starts a search at each unvisited one; a search enters a node, follows its
// edges, closes it, moves the members of a component off the stack and resumes the
// parent. The conflict check compares the components of each variable's two literals,
// and the assignment bits come from their order. The answer is ceil(n/32) result
// requests (one for an unsatisfiable problem), each held until out_stall is low.
module two_sat_scc_solver
  import tss_pkg::*;
#(
  parameter int MAX_VARS = 1024,
  parameter int MAX_CLAUSES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data,
  // clause input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [10:0] var_first,
  input  logic        val_first,
  input  logic [10:0] var_second,
  input  logic        val_second,
  input  logic        last_clause,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [4:0]  chunk_index,
  output logic [31:0] assign_bits,
  output logic        last_result
);

  localparam int VAR_LIMIT = (MAX_VARS < 1024) ? MAX_VARS : 1024;
  localparam int NODE_COUNT = 2 * VAR_LIMIT;
  localparam int NODE_DEPTH = NODE_COUNT + 1;
  localparam int NW = $clog2(NODE_DEPTH);
  localparam int EDGE_CAP = 2 * MAX_CLAUSES;
  localparam int EW = $clog2(EDGE_CAP);
  localparam int PW = $clog2(EDGE_CAP + 1);

  // State codes
  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_LOAD = 5'd1;
  localparam logic [4:0] S_LOADA = 5'd2;
  localparam logic [4:0] S_EDGE2 = 5'd3;
  localparam logic [4:0] S_ROOT = 5'd4;
  localparam logic [4:0] S_ROOTW = 5'd5;
  localparam logic [4:0] S_ENT = 5'd6;
  localparam logic [4:0] S_ENTW = 5'd7;
  localparam logic [4:0] S_TOP = 5'd8;
  localparam logic [4:0] S_EDGEW = 5'd9;
  localparam logic [4:0] S_TGTW = 5'd10;
  localparam logic [4:0] S_SCC = 5'd11;
  localparam logic [4:0] S_SCCW = 5'd12;
  localparam logic [4:0] S_PAR = 5'd13;
  localparam logic [4:0] S_PARW = 5'd14;
  localparam logic [4:0] S_PARL = 5'd15;
  localparam logic [4:0] S_CHK = 5'd16;
  localparam logic [4:0] S_CHKA = 5'd17;
  localparam logic [4:0] S_CHKB = 5'd18;
  localparam logic [4:0] S_BITS = 5'd19;
  localparam logic [4:0] S_BITA = 5'd20;
  localparam logic [4:0] S_BITB = 5'd21;
  localparam logic [4:0] S_EMIT = 5'd22;

  logic [4:0] state;

  // Registers
  logic [10:0]   var_count;
  logic [NW-1:0] n_solve;
  logic [PW-1:0] edge_count;
  logic [NW-1:0] visit_counter;
  logic [NW-1:0] scc_top;
  logic [NW-1:0] frame_top;
  logic [NW-1:0] component_count;
  logic          dropped_flag;
  logic [NW-1:0] root;
  logic [NW-1:0] cur;
  logic [PW-1:0] cur_edge;
  logic [NW-1:0] cur_low;
  logic [NW-1:0] cur_ord;
  logic [NW-1:0] tgt;
  logic          push_frame;
  logic [NW-1:0] clr_addr;
  logic [NW-1:0] neg2;
  logic [NW-1:0] lit1;
  logic          same_head;
  logic          last_q;
  logic          unsat;
  logic [4:0]    chunk;
  logic [4:0]    bitpos;
  logic [4:0]    chunk_last;
  logic [NW-1:0] comp_a;
  logic [31:0]   bits;

  // Memory ports
  logic          hd_we;   logic [NW-1:0] hd_wa, hd_ra; logic [PW-1:0] hd_wd, hd_rd;
  logic          et_we;   logic [EW-1:0] et_wa, et_ra; logic [NW-1:0] et_wd, et_rd;
  logic          el_we;   logic [EW-1:0] el_wa, el_ra; logic [PW-1:0] el_wd, el_rd;
  logic          vo_we;   logic [NW-1:0] vo_wa, vo_ra; logic [NW-1:0] vo_wd, vo_rd;
  logic          ll_we;   logic [NW-1:0] ll_wa, ll_ra; logic [NW-1:0] ll_wd, ll_rd;
  logic          os_we;   logic [NW-1:0] os_wa, os_ra; logic os_wd, os_rd;
  logic          ss_we;   logic [NW-1:0] ss_wa, ss_ra; logic [NW-1:0] ss_wd, ss_rd;
  logic          ci_we;   logic [NW-1:0] ci_wa, ci_ra; logic [NW-1:0] ci_wd, ci_rd;
  logic          fn_we;   logic [NW-1:0] fn_wa, fn_ra; logic [NW-1:0] fn_wd, fn_rd;
  logic          fe_we;   logic [NW-1:0] fe_wa, fe_ra; logic [PW-1:0] fe_wd, fe_rd;

  tss_ram #(.WIDTH(PW), .DEPTH(NODE_DEPTH)) u_head (.clk, .wr_en(hd_we), .wr_addr(hd_wa),
    .wr_data(hd_wd), .rd_addr(hd_ra), .rd_data(hd_rd));
  tss_ram #(.WIDTH(NW), .DEPTH(EDGE_CAP)) u_etgt (.clk, .wr_en(et_we), .wr_addr(et_wa),
    .wr_data(et_wd), .rd_addr(et_ra), .rd_data(et_rd));
  tss_ram #(.WIDTH(PW), .DEPTH(EDGE_CAP)) u_elink (.clk, .wr_en(el_we), .wr_addr(el_wa),
    .wr_data(el_wd), .rd_addr(el_ra), .rd_data(el_rd));
  tss_ram #(.WIDTH(NW), .DEPTH(NODE_DEPTH)) u_visit (.clk, .wr_en(vo_we), .wr_addr(vo_wa),
    .wr_data(vo_wd), .rd_addr(vo_ra), .rd_data(vo_rd));
  tss_ram #(.WIDTH(NW), .DEPTH(NODE_DEPTH)) u_low (.clk, .wr_en(ll_we), .wr_addr(ll_wa),
    .wr_data(ll_wd), .rd_addr(ll_ra), .rd_data(ll_rd));
  tss_ram #(.WIDTH(1), .DEPTH(NODE_DEPTH)) u_onstk (.clk, .wr_en(os_we), .wr_addr(os_wa),
    .wr_data(os_wd), .rd_addr(os_ra), .rd_data(os_rd));
  tss_ram #(.WIDTH(NW), .DEPTH(NODE_DEPTH)) u_stk (.clk, .wr_en(ss_we), .wr_addr(ss_wa),
    .wr_data(ss_wd), .rd_addr(ss_ra), .rd_data(ss_rd));
  tss_ram #(.WIDTH(NW), .DEPTH(NODE_DEPTH)) u_comp (.clk, .wr_en(ci_we), .wr_addr(ci_wa),
    .wr_data(ci_wd), .rd_addr(ci_ra), .rd_data(ci_rd));
  tss_ram #(.WIDTH(NW), .DEPTH(NODE_DEPTH)) u_fnode (.clk, .wr_en(fn_we), .wr_addr(fn_wa),
    .wr_data(fn_wd), .rd_addr(fn_ra), .rd_data(fn_rd));
  tss_ram #(.WIDTH(PW), .DEPTH(NODE_DEPTH)) u_fedge (.clk, .wr_en(fe_we), .wr_addr(fe_wa),
    .wr_data(fe_wd), .rd_addr(fe_ra), .rd_data(fe_rd));

  // Effective variable count, clamped
  logic [NW-1:0] n_eff;
  always_comb begin
    if (var_count == 11'd0) begin
      n_eff = NW'(1);
    end else if (32'(var_count) > VAR_LIMIT) begin
      n_eff = NW'(VAR_LIMIT);
    end else begin
      n_eff = NW'(var_count);
    end
  end

  // Clause decode
  logic          bad;
  logic [NW-1:0] vi, vj, neg1, lit2, neg2_in, lit1_in;
  logic [NW-1:0] n2;
  always_comb begin
    vi = NW'(var_first);
    vj = NW'(var_second);
    bad = (var_first == 11'd0) || (var_second == 11'd0) ||
          (32'(var_first) > 32'(n_eff)) || (32'(var_second) > 32'(n_eff)) ||
          (edge_count > PW'(EDGE_CAP - 2));
    neg1 = val_first ? vi : vi + n_eff;
    lit2 = val_second ? vj + n_eff : vj;
    neg2_in = val_second ? vj : vj + n_eff;
    lit1_in = val_first ? vi + n_eff : vi;
    n2 = n_solve << 1;
  end

  logic          in_acc;
  logic [PW-1:0] new_ptr;
  assign in_stall = (state != S_LOADA);
  assign in_acc = in_valid && !in_stall;
  assign cfg_ready = ((state == S_CLEAR) || (state == S_LOAD)) && !in_valid;
  assign out_valid = (state == S_EMIT);
  assign status = unsat ? STATUS_UNSAT : (dropped_flag ? STATUS_DROPPED : STATUS_SAT);
  assign chunk_index = chunk;
  assign assign_bits = bits;
  assign last_result = unsat || (chunk == chunk_last);
  assign new_ptr = edge_count + PW'(1);

  // Memory control
  always_comb begin
    hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_ra = '0;
    et_we = 1'b0; et_wa = '0; et_wd = '0; et_ra = '0;
    el_we = 1'b0; el_wa = '0; el_wd = '0; el_ra = '0;
    vo_we = 1'b0; vo_wa = '0; vo_wd = '0; vo_ra = '0;
    ll_we = 1'b0; ll_wa = '0; ll_wd = '0; ll_ra = '0;
    os_we = 1'b0; os_wa = '0; os_wd = 1'b0; os_ra = '0;
    ss_we = 1'b0; ss_wa = '0; ss_wd = '0; ss_ra = '0;
    ci_we = 1'b0; ci_wa = '0; ci_wd = '0; ci_ra = '0;
    fn_we = 1'b0; fn_wa = '0; fn_wd = '0; fn_ra = '0;
    fe_we = 1'b0; fe_wa = '0; fe_wd = '0; fe_ra = '0;
    unique case (state)
      S_CLEAR: begin
        hd_we = 1'b1; hd_wa = clr_addr;
        vo_we = 1'b1; vo_wa = clr_addr;
        os_we = 1'b1; os_wa = clr_addr;
      end
      S_LOAD: begin
        // fetch the head of the first endpoint while the request waits
        hd_ra = neg1;
      end
      S_LOADA: begin
        // first edge: neg1 -> lit2; fetch head of neg2
        hd_ra = neg2_in;
        if (in_acc && !bad) begin
          hd_we = 1'b1; hd_wa = neg1; hd_wd = new_ptr;
          et_we = 1'b1; et_wa = EW'(edge_count); et_wd = lit2;
          el_we = 1'b1; el_wa = EW'(edge_count); el_wd = hd_rd;
        end
      end
      S_EDGE2: begin
        // second edge: neg2 -> lit1, forward the first edge when heads coincide
        hd_we = 1'b1; hd_wa = neg2; hd_wd = new_ptr;
        et_we = 1'b1; et_wa = EW'(edge_count); et_wd = lit1;
        el_we = 1'b1; el_wa = EW'(edge_count); el_wd = same_head ? edge_count : hd_rd;
      end
      S_ROOT: begin
        vo_ra = root;
      end
      S_ENT: begin
        hd_ra = tgt;
        if (push_frame) begin
          fn_we = 1'b1; fn_wa = frame_top; fn_wd = cur;
          fe_we = 1'b1; fe_wa = frame_top; fe_wd = cur_edge;
          ll_we = 1'b1; ll_wa = cur; ll_wd = cur_low;
        end
      end
      S_ENTW: begin
        vo_we = 1'b1; vo_wa = tgt; vo_wd = visit_counter + NW'(1);
        os_we = 1'b1; os_wa = tgt; os_wd = 1'b1;
        ss_we = 1'b1; ss_wa = scc_top; ss_wd = tgt;
      end
      S_TOP: begin
        et_ra = EW'(cur_edge - PW'(1));
        el_ra = EW'(cur_edge - PW'(1));
      end
      S_EDGEW: begin
        vo_ra = et_rd;
        os_ra = et_rd;
      end
      S_SCC: begin
        ss_ra = scc_top - NW'(1);
      end
      S_SCCW: begin
        os_we = 1'b1; os_wa = ss_rd;
        ci_we = 1'b1; ci_wa = ss_rd; ci_wd = component_count;
      end
      S_PAR: begin
        fn_ra = frame_top - NW'(1);
        fe_ra = frame_top - NW'(1);
      end
      S_PARW: begin
        ll_ra = fn_rd;
        vo_ra = fn_rd;
      end
      S_CHK: begin
        ci_ra = root;
      end
      S_CHKA: begin
        ci_ra = root + n_solve;
      end
      S_BITS: begin
        ci_ra = root;
      end
      S_BITA: begin
        ci_ra = root + n_solve;
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      var_count <= 11'd1;
      edge_count <= '0;
      visit_counter <= '0;
      scc_top <= '0;
      frame_top <= '0;
      component_count <= '0;
      dropped_flag <= 1'b0;
      unsat <= 1'b0;
      chunk <= '0;
      bits <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        var_count <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + NW'(1);
          if (clr_addr == NW'(NODE_COUNT)) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (in_valid) begin
            state <= S_LOADA;
          end
        end
        S_LOADA: begin
          if (in_valid) begin
            n_solve <= n_eff;
            if (bad) begin
              dropped_flag <= 1'b1;
              if (last_clause) begin
                root <= NW'(1);
                state <= S_ROOT;
              end else begin
                state <= S_LOAD;
              end
            end else begin
              neg2 <= neg2_in;
              lit1 <= lit1_in;
              same_head <= (neg2_in == neg1);
              last_q <= last_clause;
              edge_count <= new_ptr;
              state <= S_EDGE2;
            end
          end else begin
            state <= S_LOAD;
          end
        end
        S_EDGE2: begin
          edge_count <= new_ptr;
          if (last_q) begin
            root <= NW'(1);
            state <= S_ROOT;
          end else begin
            state <= S_LOAD;
          end
        end
        S_ROOT: begin
          state <= S_ROOTW;
        end
        S_ROOTW: begin
          // start a search from an unvisited root, else advance the scan
          if (vo_rd == '0) begin
            tgt <= root;
            push_frame <= 1'b0;
            state <= S_ENT;
          end else if (root == n2) begin
            root <= NW'(1);
            state <= S_CHK;
          end else begin
            root <= root + NW'(1);
            state <= S_ROOT;
          end
        end
        S_ENT: begin
          if (push_frame) begin
            frame_top <= frame_top + NW'(1);
          end
          state <= S_ENTW;
        end
        S_ENTW: begin
          cur <= tgt;
          cur_edge <= hd_rd;
          cur_low <= visit_counter + NW'(1);
          cur_ord <= visit_counter + NW'(1);
          visit_counter <= visit_counter + NW'(1);
          scc_top <= scc_top + NW'(1);
          state <= S_TOP;
        end
        S_TOP: begin
          if (cur_edge != '0) begin
            state <= S_EDGEW;
          end else if (cur_low == cur_ord) begin
            component_count <= component_count + NW'(1);
            state <= S_SCC;
          end else begin
            state <= S_PAR;
          end
        end
        S_EDGEW: begin
          tgt <= et_rd;
          cur_edge <= el_rd;
          state <= S_TGTW;
        end
        S_TGTW: begin
          if (vo_rd == '0) begin
            push_frame <= 1'b1;
            state <= S_ENT;
          end else begin
            if (os_rd && vo_rd < cur_low) begin
              cur_low <= vo_rd;
            end
            state <= S_TOP;
          end
        end
        S_SCC: begin
          state <= S_SCCW;
        end
        S_SCCW: begin
          // pop members until the component root comes off
          scc_top <= scc_top - NW'(1);
          if (ss_rd == cur) begin
            state <= S_PAR;
          end else begin
            state <= S_SCC;
          end
        end
        S_PAR: begin
          if (frame_top == '0) begin
            state <= S_ROOT;
          end else begin
            state <= S_PARW;
          end
        end
        S_PARW: begin
          cur <= fn_rd;
          cur_edge <= fe_rd;
          state <= S_PARL;
        end
        S_PARL: begin
          // fold the child's low link into the resumed parent
          cur_ord <= vo_rd;
          cur_low <= (cur_low < ll_rd) ? cur_low : ll_rd;
          frame_top <= frame_top - NW'(1);
          state <= S_TOP;
        end
        S_CHK: begin
          state <= S_CHKA;
        end
        S_CHKA: begin
          comp_a <= ci_rd;
          state <= S_CHKB;
        end
        S_CHKB: begin
          if (comp_a == ci_rd) begin
            unsat <= 1'b1;
          end
          if (root == n_solve) begin
            root <= NW'(1);
            chunk <= '0;
            bitpos <= '0;
            bits <= '0;
            chunk_last <= 5'((n_solve - NW'(1)) >> 5);
            state <= (unsat || comp_a == ci_rd) ? S_EMIT : S_BITS;
          end else begin
            root <= root + NW'(1);
            state <= S_CHK;
          end
        end
        S_BITS: begin
          state <= S_BITA;
        end
        S_BITA: begin
          comp_a <= ci_rd;
          state <= S_BITB;
        end
        S_BITB: begin
          bits[bitpos] <= (comp_a > ci_rd);
          if (root == n_solve || bitpos == 5'd31) begin
            state <= S_EMIT;
          end else begin
            state <= S_BITS;
          end
          root <= root + NW'(1);
          bitpos <= bitpos + 5'd1;
        end
        S_EMIT: begin
          if (!out_stall) begin
            if (last_result) begin
              state <= S_CLEAR;
              clr_addr <= '0;
              edge_count <= '0;
              visit_counter <= '0;
              scc_top <= '0;
              frame_top <= '0;
              component_count <= '0;
              dropped_flag <= 1'b0;
              unsat <= 1'b0;
            end else begin
              chunk <= chunk + 5'd1;
              bits <= '0;
              bitpos <= '0;
              state <= S_BITS;
            end
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

endmodule
